// ----- rtl/slmi_pkg.sv -----
// Shared types and constants for the servo linear-motion interpolator.
`default_nettype none

package slmi_pkg;

	localparam int NUM_SERVOS_DEF = 8;
	localparam int SC_W           = 4;
	localparam int POS_W          = 16;
	localparam int TIME_W         = 16;
	localparam int CH_W           = 3;
	localparam int WHOLE_W        = 8;
	localparam int FRAC_BITS      = 8;
	localparam int MD_BITS        = 16;

	localparam logic [SC_W-1:0] SC_RESET = 4'd8;

	localparam logic OP_MOVE     = 1'b0;
	localparam logic OP_TICK     = 1'b1;
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_FRAME  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MD,
		ST_WB,
		ST_EMIT,
		ST_FRAME
	} slmi_state_t;

	typedef struct packed {
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  tgt;
		logic [TIME_W-1:0] rem;
		logic              act;
	} slmi_chan_t;

	typedef struct packed {
		logic              en;
		logic [CH_W-1:0]   ch;
		logic [POS_W-1:0]  tgt;
		logic [TIME_W-1:0] rem;
	} slmi_move_t;

	typedef struct packed {
		logic              en;
		logic [POS_W-1:0]  pos;
		logic [TIME_W-1:0] rem;
		logic              act;
	} slmi_upd_t;

	typedef struct packed {
		logic               start;
		logic [MD_BITS-1:0] mag;
		logic [MD_BITS-1:0] mult;
		logic [MD_BITS-1:0] divisor;
	} slmi_md_req_t;

	typedef struct packed {
		logic               done;
		logic [MD_BITS-1:0] quot;
	} slmi_md_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/slmi_serial_muldiv.sv -----
// Bit-serial unsigned multiply followed by restoring divide, one bit per cycle.
`default_nettype none

module slmi_serial_muldiv import slmi_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire slmi_md_req_t req,
	output slmi_md_rsp_t      rsp
);

	logic [2*MD_BITS-1:0] acc_q;
	logic [MD_BITS-1:0]   m_q;
	logic [MD_BITS-1:0]   mag_q;
	logic [MD_BITS-1:0]   div_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [MD_BITS:0]     mul_sum;
	logic [MD_BITS:0]     div_try;
	logic                 div_ge;
	logic [MD_BITS:0]     div_rem;

	// multiply: add into the upper half, shift the whole accumulator right
	always_comb begin
		mul_sum = {1'b0, acc_q[2*MD_BITS-1:MD_BITS]} + (m_q[0] ? {1'b0, mag_q} : '0);
	end

	// divide: upper half is the partial remainder, lower half collects quotient bits
	always_comb begin
		div_try = {acc_q[2*MD_BITS-1:MD_BITS], acc_q[MD_BITS-1]};
		div_ge  = div_try >= {1'b0, div_q};
		div_rem = div_ge ? (div_try - {1'b0, div_q}) : div_try;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			m_q   <= req.mult;
			mag_q <= req.mag;
			div_q <= req.divisor;
		end else if (busy_q) begin
			if (!cnt_q[4]) begin
				acc_q <= {mul_sum, acc_q[MD_BITS-1:1]};
				m_q   <= {1'b0, m_q[MD_BITS-1:1]};
			end else begin
				acc_q <= {div_rem[MD_BITS-1:0], acc_q[MD_BITS-2:0], div_ge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q[MD_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/slmi_chan_bank.sv -----
// Per-channel position, target, remaining time and active flag registers.
`default_nettype none

module slmi_chan_bank import slmi_pkg::*; #(
	parameter  int NUM_SERVOS = NUM_SERVOS_DEF,
	localparam int IDX_W      = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire slmi_move_t       mv,
	input  wire slmi_upd_t        upd,
	input  wire logic [IDX_W-1:0] upd_idx,
	input  wire logic [IDX_W-1:0] rd_idx,
	output slmi_chan_t            rd
);

	logic [POS_W-1:0]  pos_q [NUM_SERVOS];
	logic [POS_W-1:0]  tgt_q [NUM_SERVOS];
	logic [TIME_W-1:0] rem_q [NUM_SERVOS];
	logic [NUM_SERVOS-1:0] act_q;

	logic             mv_hit;
	logic [IDX_W-1:0] mv_idx;

	// moves to channels outside the bank are dropped
	assign mv_hit = mv.en && (32'(mv.ch) < NUM_SERVOS);
	assign mv_idx = IDX_W'(mv.ch);

	for (genvar i = 0; i < NUM_SERVOS; i++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_q[i] <= '0;
				tgt_q[i] <= '0;
				rem_q[i] <= '0;
				act_q[i] <= 1'b0;
			end else if (upd.en && upd_idx == IDX_W'(i)) begin
				pos_q[i] <= upd.pos;
				rem_q[i] <= upd.rem;
				act_q[i] <= upd.act;
			end else if (mv_hit && mv_idx == IDX_W'(i)) begin
				tgt_q[i] <= mv.tgt;
				rem_q[i] <= mv.rem;
				act_q[i] <= 1'b1;
			end
		end
	end

	assign rd.pos = pos_q[rd_idx];
	assign rd.tgt = tgt_q[rd_idx];
	assign rd.rem = rem_q[rd_idx];
	assign rd.act = act_q[rd_idx];

endmodule

`default_nettype wire

// ----- rtl/servo_linear_motion_interpolator.sv -----
// Top level of the multichannel servo linear-motion interpolator.
`default_nettype none

// Keeps NUM_SERVOS servo channels, each with a signed 8.8 position, a target, the
// move time left and an active flag. A move request (op = 0) loads target and
// duration into one channel and returns nothing; it is taken while the block is idle. A
// tick request (op = 1) carries the time counter; the elapsed time since the
// previous tick advances each active channel among the first servo_count ones
// linearly toward its target, each channel whose whole part changed is reported
// (kind = 0), and a frame marker (kind = 1, last = 1) closes the tick.
// Per tick the request is accepted, then each channel is visited in turn: an
// inactive one is skipped, one that reaches its target is written back, and one
// still moving first waits on the shared bit-serial multiply/divide unit (16
// multiply steps, 16 divide steps); each changed channel then gets its update, and
// once the scan is seen to be done the frame marker follows. Updates and the marker
// wait while the output register stays full. One request is worked on at a
// time; a new request is accepted as soon as the previous tick has handed its
// marker to the output register, even if that marker is still waiting there.
// servo_count (cfg_wdata) resets to 8, saturates at NUM_SERVOS and should be
// written only when idle.
module servo_linear_motion_interpolator import slmi_pkg::*; #(
	parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [SC_W-1:0]          cfg_wdata,
	input  wire logic                     cmd_valid,
	output logic                          cmd_ready,
	input  wire logic                     op,
	input  wire logic [CH_W-1:0]          channel,
	input  wire logic signed [POS_W-1:0]  target_position,
	input  wire logic [TIME_W-1:0]        move_duration,
	input  wire logic [TIME_W-1:0]        current_time,
	output logic                          res_valid,
	input  wire logic                     res_ready,
	output logic                          kind,
	output logic [CH_W-1:0]               out_channel,
	output logic signed [WHOLE_W-1:0]     whole_position,
	output logic                          last
);

	localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
	localparam int CNT_W = $clog2(NUM_SERVOS + 1);

	slmi_state_t state_q, state_nx;

	logic [SC_W-1:0]   servo_count_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              sign_q;
	logic [POS_W-1:0]  newpos_q;
	logic [TIME_W-1:0] newrem_q;
	logic              newact_q;

	logic               res_valid_q;
	logic               kind_q;
	logic [CH_W-1:0]    och_q;
	logic [WHOLE_W-1:0] whole_q;
	logic               last_q;

	slmi_chan_t   rd;
	slmi_move_t   mv;
	slmi_upd_t    upd;
	slmi_md_req_t md_req;
	slmi_md_rsp_t md_rsp;

	logic             scan_done;
	logic             snap;
	logic [POS_W:0]   diff;
	logic [POS_W-1:0] diff_mag;
	logic [POS_W-1:0] delta;
	logic [POS_W-1:0] md_pos;
	logic             changed;
	logic             slot_free;
	logic             tick_go;
	logic             take_snap;
	logic             k_inc;
	logic             load_upd;
	logic             load_frame;
	logic [CNT_W-1:0] cnt_sat;

	slmi_chan_bank #(
		.NUM_SERVOS(NUM_SERVOS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.mv     (mv),
		.upd    (upd),
		.upd_idx(k_q[IDX_W-1:0]),
		.rd_idx (k_q[IDX_W-1:0]),
		.rd     (rd)
	);

	slmi_serial_muldiv u_md (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (md_req),
		.rsp   (md_rsp)
	);

	// datapath around the channel being scanned
	always_comb begin
		scan_done = (k_q == cnt_q);
		snap      = elapsed_q >= rd.rem;
		diff      = {rd.tgt[POS_W-1], rd.tgt} - {rd.pos[POS_W-1], rd.pos};
		diff_mag  = diff[POS_W] ? POS_W'(~diff + 1'b1) : diff[POS_W-1:0];
		// quotient is |diff|*elapsed/remaining; sign put back gives truncation toward zero
		delta     = sign_q ? (~md_rsp.quot + 1'b1) : md_rsp.quot;
		md_pos    = rd.pos + delta;
		changed   = newpos_q[POS_W-1:FRAC_BITS] != rd.pos[POS_W-1:FRAC_BITS];
		slot_free = !res_valid_q || res_ready;
		cnt_sat   = (32'(servo_count_q) > NUM_SERVOS) ? CNT_W'(NUM_SERVOS)
		                                               : CNT_W'(servo_count_q);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && op == OP_TICK)
					state_nx = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done)
					state_nx = ST_FRAME;
				else if (rd.act)
					state_nx = snap ? ST_WB : ST_MD;
			end
			ST_MD: begin
				if (md_rsp.done)
					state_nx = ST_WB;
			end
			ST_WB: begin
				state_nx = changed ? ST_EMIT : ST_SCAN;
			end
			ST_EMIT: begin
				if (slot_free)
					state_nx = ST_SCAN;
			end
			ST_FRAME: begin
				if (slot_free)
					state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		cmd_ready      = (state_q == ST_IDLE);
		mv.en          = cmd_ready && cmd_valid && op == OP_MOVE;
		mv.ch          = channel;
		mv.tgt         = target_position;
		mv.rem         = move_duration;
		tick_go        = cmd_ready && cmd_valid && op == OP_TICK;
		take_snap      = (state_q == ST_SCAN) && !scan_done && rd.act && snap;
		md_req.start   = (state_q == ST_SCAN) && !scan_done && rd.act && !snap;
		md_req.mag     = diff_mag;
		md_req.mult    = elapsed_q;
		md_req.divisor = rd.rem;
		upd.en         = (state_q == ST_WB);
		upd.pos        = newpos_q;
		upd.rem        = newrem_q;
		upd.act        = newact_q;
		load_upd       = (state_q == ST_EMIT) && slot_free;
		load_frame     = (state_q == ST_FRAME) && slot_free;
		k_inc          = ((state_q == ST_SCAN) && !scan_done && !rd.act) ||
		                 ((state_q == ST_WB) && !changed) || load_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			servo_count_q <= SC_RESET;
			last_time_q   <= '0;
			k_q           <= '0;
			cnt_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we)
				servo_count_q <= cfg_wdata;
			if (tick_go) begin
				last_time_q <= current_time;
				k_q         <= '0;
				cnt_q       <= cnt_sat;
			end else if (k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (load_upd || load_frame)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go)
			elapsed_q <= current_time - last_time_q;
		if (take_snap) begin
			newpos_q <= rd.tgt;
			newrem_q <= '0;
			newact_q <= 1'b0;
		end else if (md_req.start) begin
			sign_q   <= diff[POS_W];
			newrem_q <= rd.rem - elapsed_q;
			newact_q <= 1'b1;
		end else if (state_q == ST_MD && md_rsp.done) begin
			newpos_q <= md_pos;
		end
		if (load_upd) begin
			kind_q  <= KIND_UPDATE;
			och_q   <= CH_W'(k_q);
			whole_q <= newpos_q[POS_W-1:FRAC_BITS];
			last_q  <= 1'b0;
		end else if (load_frame) begin
			kind_q  <= KIND_FRAME;
			och_q   <= '0;
			whole_q <= '0;
			last_q  <= 1'b1;
		end
	end

	assign res_valid      = res_valid_q;
	assign kind           = kind_q;
	assign out_channel    = och_q;
	assign whole_position = whole_q;
	assign last           = last_q;

`ifndef SYNTHESIS
	a_done_in_md: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == ST_MD)
		else $error("multiply/divide finished outside its wait state");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> k_q <= cnt_q)
		else $error("scan index ran past the channel count");

	a_snap_target: assert property (@(posedge clk) disable iff (!arst_n)
		(upd.en && !upd.act) |-> (newpos_q == rd.tgt && newrem_q == '0))
		else $error("finished channel not written at its target");

	a_frame_out: assert property (@(posedge clk) disable iff (!arst_n)
		load_frame |=> (res_valid && kind == KIND_FRAME && last && state_q == ST_IDLE))
		else $error("frame marker not presented at end of tick");
`endif

endmodule

`default_nettype wire

// ----- verif/servo_motion_checker.sv -----
// Watches the servo interpolator's request and result channels, predicts each result and compares.
module servo_motion_checker import slmi_pkg::*; #(
	parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [SC_W-1:0]         cfg_wdata,
	input  wire logic                    cmd_valid,
	input  wire logic                    cmd_ready,
	input  wire logic                    op,
	input  wire logic [CH_W-1:0]         channel,
	input  wire logic signed [POS_W-1:0] target_position,
	input  wire logic [TIME_W-1:0]       move_duration,
	input  wire logic [TIME_W-1:0]       current_time,
	input  wire logic                    res_valid,
	input  wire logic                    res_ready,
	input  wire logic                    kind,
	input  wire logic [CH_W-1:0]         out_channel,
	input  wire logic signed [WHOLE_W-1:0] whole_position,
	input  wire logic                    last,
	output int                           failures,
	output int                           owed,
	output int                           updates_seen,
	output int                           frames_seen
);

	typedef struct packed {
		logic                      kind;
		logic [CH_W-1:0]           ch;
		logic signed [WHOLE_W-1:0] whole;
		logic                      last;
	} servo_report_t;

	servo_report_t     pending_reports[$];
	logic [POS_W-1:0]  servo_pos [NUM_SERVOS];
	logic [POS_W-1:0]  servo_tgt [NUM_SERVOS];
	logic [TIME_W-1:0] servo_rem [NUM_SERVOS];
	logic              servo_act [NUM_SERVOS];
	logic [TIME_W-1:0] prev_tick;
	logic [SC_W-1:0]   scan_count;
	int                errs = 0;
	int                n_upd = 0;
	int                n_frm = 0;

	initial begin
		failures     = 0;
		owed         = 0;
		updates_seen = 0;
		frames_seen  = 0;
	end

	// move request: load one channel; channels past the bank are dropped
	task automatic load_move(input logic [CH_W-1:0] ch, input logic [POS_W-1:0] tgt,
			input logic [TIME_W-1:0] dur);
		if (ch < NUM_SERVOS) begin
			servo_tgt[ch] = tgt;
			servo_rem[ch] = dur;
			servo_act[ch] = 1'b1;
		end
	endtask

	// tick request: step the scanned channels and queue the reports it owes
	task automatic advance_servos(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] elapsed;
		logic [POS_W-1:0]  was;
		longint            span;
		longint            step;
		longint            nxt;
		int                lanes;
		servo_report_t     r;
		elapsed   = now - prev_tick;
		prev_tick = now;
		lanes     = (scan_count > NUM_SERVOS) ? NUM_SERVOS : int'(scan_count);
		for (int k = 0; k < lanes; k++) begin
			if (servo_act[k]) begin
				was = servo_pos[k];
				if (elapsed >= servo_rem[k]) begin
					servo_pos[k] = servo_tgt[k];
					servo_rem[k] = '0;
					servo_act[k] = 1'b0;
				end else begin
					span = longint'($signed(servo_tgt[k])) - longint'($signed(was));
					// SV division truncates toward zero
					step = (span * longint'(elapsed)) / longint'(servo_rem[k]);
					nxt  = longint'($signed(was)) + step;
					servo_pos[k] = nxt[POS_W-1:0];
					servo_rem[k] = servo_rem[k] - elapsed;
				end
				if (was[POS_W-1:FRAC_BITS] != servo_pos[k][POS_W-1:FRAC_BITS]) begin
					r.kind  = KIND_UPDATE;
					r.ch    = CH_W'(k);
					r.whole = servo_pos[k][POS_W-1:FRAC_BITS];
					r.last  = 1'b0;
					pending_reports.push_back(r);
				end
			end
		end
		r.kind  = KIND_FRAME;
		r.ch    = '0;
		r.whole = '0;
		r.last  = 1'b1;
		pending_reports.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		servo_report_t want;
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVOS; k++) begin
				servo_pos[k] = '0;
				servo_tgt[k] = '0;
				servo_rem[k] = '0;
				servo_act[k] = 1'b0;
			end
			prev_tick  = '0;
			scan_count = SC_RESET;
			pending_reports.delete();
		end else begin
			// results first: a waiting marker can leave as the next request enters
			if (res_valid && res_ready) begin
				if (pending_reports.size() == 0) begin
					errs++;
					$display("%0t: unexpected result kind %0d channel %0d whole %0d last %0d",
						$time, kind, out_channel, whole_position, last);
				end else begin
					want = pending_reports.pop_front();
					if (want.kind == KIND_FRAME)
						n_frm++;
					else
						n_upd++;
					if (kind != want.kind) begin
						errs++;
						$display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
					end
					if (out_channel != want.ch) begin
						errs++;
						$display("%0t: out_channel expected %0d, got %0d",
							$time, want.ch, out_channel);
					end
					if (whole_position != want.whole) begin
						errs++;
						$display("%0t: whole_position expected %0d, got %0d",
							$time, want.whole, whole_position);
					end
					if (last != want.last) begin
						errs++;
						$display("%0t: last expected %0d, got %0d", $time, want.last, last);
					end
				end
			end
			if (cfg_we)
				scan_count = cfg_wdata;
			if (cmd_valid && cmd_ready) begin
				if (op == OP_MOVE)
					load_move(channel, target_position, move_duration);
				else
					advance_servos(current_time);
			end
		end
		failures     <= errs;
		owed         <= pending_reports.size();
		updates_seen <= n_upd;
		frames_seen  <= n_frm;
	end

endmodule

// ----- verif/servo_linear_motion_interpolator_test.sv -----
// Stimulus and verdict for the servo linear-motion interpolator.
module servo_linear_motion_interpolator_test;
	import slmi_pkg::*;

	// watchdog limit, kept far above what a legal run needs
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 78;

	logic                      clk             = 1'b0;
	logic                      arst_n          = 1'b0;
	logic                      cfg_we          = 1'b0;
	logic [SC_W-1:0]           cfg_wdata       = '0;
	logic                      cmd_valid       = 1'b0;
	logic                      op              = OP_MOVE;
	logic [CH_W-1:0]           channel         = '0;
	logic signed [POS_W-1:0]   target_position = '0;
	logic [TIME_W-1:0]         move_duration   = '0;
	logic [TIME_W-1:0]         current_time    = '0;
	logic                      res_ready       = 1'b0;
	logic                      cmd_ready;
	logic                      res_valid;
	logic                      kind;
	logic [CH_W-1:0]           out_channel;
	logic signed [WHOLE_W-1:0] whole_position;
	logic                      last;

	int   failures;
	int   owed;
	int   updates_seen;
	int   frames_seen;
	int   cycles      = 0;
	int   hold_off    = 0;
	int   moves_sent  = 0;
	int   ticks_sent  = 0;
	logic calm        = 1'b0;    // no idling on either side when set

	servo_linear_motion_interpolator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.op             (op),
		.channel        (channel),
		.target_position(target_position),
		.move_duration  (move_duration),
		.current_time   (current_time),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.kind           (kind),
		.out_channel    (out_channel),
		.whole_position (whole_position),
		.last           (last)
	);

	servo_motion_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.op             (op),
		.channel        (channel),
		.target_position(target_position),
		.move_duration  (move_duration),
		.current_time   (current_time),
		.res_valid      (res_valid),
		.res_ready      (res_ready),
		.kind           (kind),
		.out_channel    (out_channel),
		.whole_position (whole_position),
		.last           (last),
		.failures       (failures),
		.owed           (owed),
		.updates_seen   (updates_seen),
		.frames_seen    (frames_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles, owed);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side back-pressure: random stalls now and then, none when calm
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			hold_off  <= 0;
		end else if (calm) begin
			res_ready <= 1'b1;
		end else if (hold_off != 0) begin
			res_ready <= 1'b0;
			hold_off  <= hold_off - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			res_ready <= 1'b0;
			hold_off  <= $urandom_range(0, 7);
		end else begin
			res_ready <= 1'b1;
		end
	end

	// one request: an optional gap first, then hold valid until the handshake.
	// valid is left high on return so back-to-back requests never drop it.
	task automatic issue(input logic op_v, input logic [CH_W-1:0] ch,
			input logic [POS_W-1:0] tgt, input logic [TIME_W-1:0] dur,
			input logic [TIME_W-1:0] now);
		if (!calm && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		cmd_valid       <= 1'b1;
		op              <= op_v;
		channel         <= ch;
		target_position <= tgt;
		move_duration   <= dur;
		current_time    <= now;
		do @(posedge clk); while (!cmd_ready);
		if (op_v == OP_MOVE)
			moves_sent++;
		else
			ticks_sent++;
	endtask

	// move request; the time field is noise
	task automatic move(input logic [CH_W-1:0] ch, input logic [POS_W-1:0] tgt,
			input logic [TIME_W-1:0] dur);
		issue(OP_MOVE, ch, tgt, dur, TIME_W'($urandom));
	endtask

	// tick request; the move fields are noise
	task automatic tick(input logic [TIME_W-1:0] now);
		issue(OP_TICK, CH_W'($urandom), POS_W'($urandom), TIME_W'($urandom), now);
	endtask

	// drop valid, wait for every owed result, then let the block fall idle
	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		logic [SC_W-1:0]   scan_plan [PHASES];
		logic [TIME_W-1:0] clock_now;
		logic [POS_W-1:0]  tgt;
		logic [TIME_W-1:0] dur;
		int                pick;

		scan_plan[0] = 4'd15;    // beyond the bank: saturates
		scan_plan[1] = 4'd0;     // nothing scanned, marker only
		scan_plan[2] = 4'd1;
		scan_plan[3] = SC_W'($urandom_range(2, 7));
		scan_plan[4] = 4'd9;
		scan_plan[5] = 4'd8;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset count of eight
		tick(16'h0000);                 // nothing active yet
		move(3'd0, 16'h7FFF, 16'd0);    // zero duration: snaps on next tick
		move(3'd7, 16'h8000, 16'hFFFF);
		move(3'd1, 16'h0100, 16'd4);
		move(3'd2, 16'hFF00, 16'd3);
		move(3'd3, 16'h1234, 16'd10);
		move(3'd4, 16'h7F00, 16'd100);
		tick(16'h0001);
		tick(16'h0003);
		move(3'd1, 16'h8000, 16'd2);    // retarget mid-move
		tick(16'hFFF0);                 // long jump: most channels land
		move(3'd4, 16'h8000, 16'd40);
		move(3'd5, 16'h00FF, 16'd1);    // whole part unchanged, no update
		tick(16'h0008);                 // time counter wraps
		tick(16'h0008);                 // no time passed
		tick(16'h0030);
		clock_now = 16'h0030;

		// random phases, one servo count each; the last runs without idling
		for (int p = 0; p < PHASES; p++) begin
			settle();
			cfg_we    <= 1'b1;
			cfg_wdata <= scan_plan[p];
			@(posedge clk);
			cfg_we    <= 1'b0;
			calm      <= (p == PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender holds off mid-phase until every result is in
				if (i == PHASE_ITEMS / 2)
					settle();
				if ($urandom_range(0, 99) < 55) begin
					pick = $urandom_range(0, 7);
					if (pick == 0)
						tgt = 16'h7FFF;
					else if (pick == 1)
						tgt = 16'h8000;
					else
						tgt = POS_W'($urandom);
					pick = $urandom_range(0, 9);
					if (pick == 0)
						dur = '0;
					else if (pick == 1)
						dur = TIME_W'($urandom);
					else
						dur = TIME_W'($urandom_range(1, 400));
					move(CH_W'($urandom_range(0, 7)), tgt, dur);
				end else begin
					// mostly short steps so moves span several ticks; now and then a
					// big jump that lands everything or wraps the counter
					if ($urandom_range(0, 11) == 0)
						clock_now = clock_now + TIME_W'($urandom);
					else
						clock_now = clock_now + TIME_W'($urandom_range(0, 80));
					tick(clock_now);
				end
			end
		end

		cmd_valid <= 1'b0;
		do @(posedge clk); while (owed != 0);
		repeat (40) @(posedge clk);

		$display("Covered %0d move and %0d tick requests with servo counts 8, 15, 0, 1, %0d, 9, 8.",
			moves_sent, ticks_sent, scan_plan[3]);
		$display("Checked %0d position updates and %0d frame markers.",
			updates_seen, frames_seen);
		if (failures == 0 && owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
